FILE: sv/qtue_pkg.sv
// ----------------------------------------------------------------------------
// qtue_pkg
// Shared types and constants of the Q table update engine.
// ----------------------------------------------------------------------------
package qtue_pkg;

    localparam int STATE_W = 4;
    localparam int KEY_W   = 32;
    localparam int Q_W     = 32;
    localparam int FRAC_W  = 17;
    localparam int ENTRY_W = STATE_W + KEY_W + Q_W;
    localparam int PROD_W  = 50;
    localparam int WIDE_W  = 40;

    localparam logic [FRAC_W-1:0] Q_ONE         = 17'd65536;
    localparam logic [FRAC_W-1:0] ALPHA_RESET   = 17'd32768;
    localparam logic [FRAC_W-1:0] GAMMA_RESET   = 17'd58982;

    localparam logic CFG_LEARN_RATE = 1'b0;
    localparam logic CFG_DISCOUNT   = 1'b1;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NO_ENTRY = 2'd2;

    localparam logic [1:0] MUL_NONE    = 2'd0;
    localparam logic [1:0] MUL_GAMMA   = 2'd1;
    localparam logic [1:0] MUL_KEEP    = 2'd2;
    localparam logic [1:0] MUL_ALPHA   = 2'd3;

    typedef struct packed {
        logic       load;
        logic       rd_issue;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       sample_en;
        logic       acc_en;
        logic       commit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic is_query;
        logic out_free;
    } t_stat;

    function automatic logic signed [Q_W-1:0] f_sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/qtue_ram.sv
// ----------------------------------------------------------------------------
// qtue_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module qtue_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/qtue_ctrl.sv
// ----------------------------------------------------------------------------
// qtue_ctrl
// Controller of the Q table update engine: sequences the table scan, the
// shared multiplier steps and the commit of one transaction at a time.
// ----------------------------------------------------------------------------
module qtue_ctrl
    import qtue_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_MUL_G  = 3'd2;
    localparam logic [2:0] S_SAMPLE = 3'd3;
    localparam logic [2:0] S_MUL_B  = 3'd4;
    localparam logic [2:0] S_FINAL  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = i_stat.is_query ? S_FINAL : S_MUL_G;
                end else begin
                    w_cmd.rd_issue = 1'b1;
                end
            end
            S_MUL_G: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = MUL_GAMMA;
                n_state       = S_SAMPLE;
            end
            S_SAMPLE: begin
                w_cmd.sample_en = 1'b1;
                w_cmd.mul_en    = 1'b1;
                w_cmd.mul_sel   = MUL_KEEP;
                n_state         = S_MUL_B;
            end
            S_MUL_B: begin
                w_cmd.acc_en  = 1'b1;
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = MUL_ALPHA;
                n_state       = S_FINAL;
            end
            S_FINAL: begin
                if (i_stat.out_free) begin
                    w_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = w_cmd;

endmodule

FILE: sv/qtue_dp.sv
// ----------------------------------------------------------------------------
// qtue_dp
// Datapath of the Q table update engine: item and configuration registers,
// the entry table, the scan accumulators, one shared multiplier, rounding and
// saturation, and the result register.
// ----------------------------------------------------------------------------
module qtue_dp
    import qtue_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [FRAC_W-1:0]   i_cfg_data,
    input  logic                i_op,
    input  logic [STATE_W-1:0]  i_state_index,
    input  logic [KEY_W-1:0]    i_action_key,
    input  logic [STATE_W-1:0]  i_next_state,
    input  logic signed [15:0]  i_reward,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [1:0]          o_status,
    output logic signed [Q_W-1:0] o_q_result,
    output logic [KEY_W-1:0]    o_best_action,
    output logic                o_inserted,
    input  t_cmd                i_cmd,
    output t_stat               o_stat
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [FRAC_W-1:0]     r_alpha;
    logic [FRAC_W-1:0]     r_gamma;
    logic [FRAC_W-1:0]     w_cfg_clamped;

    logic                  r_op;
    logic [STATE_W-1:0]    r_st;
    logic [KEY_W-1:0]      r_act;
    logic [STATE_W-1:0]    r_nst;
    logic signed [15:0]    r_reward;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_addr;
    logic                  r_rd_vld;
    logic [AW-1:0]         r_rd_idx;

    logic                  r_have_max;
    logic signed [Q_W-1:0] r_maxq;
    logic [KEY_W-1:0]      r_best_act;
    logic                  r_have_pair;
    logic [AW-1:0]         r_slot;
    logic signed [Q_W-1:0] r_oldq;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [Q_W-1:0]    r_sample;

    logic                  r_out_vld;
    logic [1:0]            r_out_status;
    logic signed [Q_W-1:0] r_out_q;
    logic [KEY_W-1:0]      r_out_act;
    logic                  r_out_ins;

    logic [ENTRY_W-1:0]    w_rdata;
    logic [STATE_W-1:0]    w_rd_st;
    logic [KEY_W-1:0]      w_rd_act;
    logic signed [Q_W-1:0] w_rd_q;
    logic                  w_max_hit;
    logic                  w_pair_hit;

    logic [FRAC_W-1:0]        w_ma;
    logic signed [Q_W-1:0]    w_mb;
    logic signed [FRAC_W:0]   w_ma_s;
    logic signed [PROD_W-1:0] w_prod;

    logic signed [PROD_W-1:0] w_gq_rnd;
    logic signed [WIDE_W-1:0] w_samp_sum;
    logic signed [PROD_W:0]   w_blend;
    logic signed [PROD_W:0]   w_blend_rnd;
    logic signed [Q_W-1:0]    w_newq;

    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic                  w_can_insert;

    assign w_cfg_clamped = (i_cfg_data > Q_ONE) ? Q_ONE : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
            r_gamma <= GAMMA_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_LEARN_RATE) begin
                r_alpha <= w_cfg_clamped;
            end else begin
                r_gamma <= w_cfg_clamped;
            end
        end
    end

    qtue_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_wr_addr),
        .i_wdata ({r_st, r_act, w_newq}),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_rd_st  = w_rdata[ENTRY_W-1 -: STATE_W];
    assign w_rd_act = w_rdata[Q_W +: KEY_W];
    assign w_rd_q   = w_rdata[Q_W-1:0];

    assign w_max_hit  = r_rd_vld
                      && (w_rd_st == ((r_op == OP_QUERY) ? r_st : r_nst))
                      && (!r_have_max || (w_rd_q > r_maxq));
    assign w_pair_hit = r_rd_vld && (r_op == OP_UPDATE) && !r_have_pair
                      && (w_rd_st == r_st) && (w_rd_act == r_act);

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_GAMMA: begin
                w_ma = r_gamma;
                w_mb = r_maxq;
            end
            MUL_KEEP: begin
                w_ma = Q_ONE - r_alpha;
                w_mb = r_oldq;
            end
            MUL_ALPHA: begin
                w_ma = r_alpha;
                w_mb = r_sample;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_ma_s = {1'b0, w_ma};
    assign w_prod = w_ma_s * w_mb;

    assign w_gq_rnd   = (r_prod + PROD_W'(32768)) >>> 16;
    assign w_samp_sum = {{(WIDE_W-32){r_reward[15]}}, r_reward, 16'd0}
                      + (r_have_max ? w_gq_rnd[WIDE_W-1:0] : WIDE_W'(0));

    assign w_blend     = {r_acc[PROD_W-1], r_acc} + {r_prod[PROD_W-1], r_prod}
                       + (PROD_W+1)'(32768);
    assign w_blend_rnd = w_blend >>> 16;
    assign w_newq      = f_sat32(w_blend_rnd[WIDE_W-1:0]);

    assign w_can_insert = (r_count < DEPTH_C);
    assign w_wr_en   = i_cmd.commit && (r_op == OP_UPDATE) && (r_have_pair || w_can_insert);
    assign w_wr_addr = r_have_pair ? r_slot : r_count[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_issue;
            if (w_wr_en && !r_have_pair) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_op;
            r_st        <= i_state_index;
            r_act       <= i_action_key;
            r_nst       <= i_next_state;
            r_reward    <= i_reward;
            r_addr      <= '0;
            r_have_max  <= 1'b0;
            r_maxq      <= '0;
            r_best_act  <= '0;
            r_have_pair <= 1'b0;
            r_slot      <= '0;
            r_oldq      <= '0;
        end else begin
            if (i_cmd.rd_issue) begin
                r_addr <= r_addr + CW'(1);
            end
            if (w_max_hit) begin
                r_have_max <= 1'b1;
                r_maxq     <= w_rd_q;
                r_best_act <= w_rd_act;
            end
            if (w_pair_hit) begin
                r_have_pair <= 1'b1;
                r_slot      <= r_rd_idx;
                r_oldq      <= w_rd_q;
            end
        end
        r_rd_idx <= r_addr[AW-1:0];
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.acc_en) begin
            r_acc <= r_prod;
        end
        if (i_cmd.sample_en) begin
            r_sample <= f_sat32(w_samp_sum);
        end
        if (i_cmd.commit) begin
            if (r_op == OP_QUERY) begin
                r_out_status <= r_have_max ? ST_OK : ST_NO_ENTRY;
                r_out_q      <= r_maxq;
                r_out_act    <= r_best_act;
                r_out_ins    <= 1'b0;
            end else begin
                r_out_status <= (r_have_pair || w_can_insert) ? ST_OK : ST_FULL;
                r_out_q      <= w_newq;
                r_out_act    <= '0;
                r_out_ins    <= !r_have_pair && w_can_insert;
            end
        end
    end

    assign o_stat.scan_done = (r_addr == r_count);
    assign o_stat.is_query  = (r_op == OP_QUERY);
    assign o_stat.out_free  = !r_out_vld || i_out_ready;

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_out_status;
    assign o_q_result    = r_out_q;
    assign o_best_action = r_out_act;
    assign o_inserted    = r_out_ins;

endmodule

FILE: sv/q_table_update_engine.sv
// ----------------------------------------------------------------------------
// q_table_update_engine
// Tabular Q value update and best action lookup over a bounded entry table.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time. A transaction scans every stored
// entry once through the single read port of the table RAM, one entry per
// cycle; the number of stored entries is at most TABLE_DEPTH. Q values are
// signed Q16.16 and saturate; learn_rate and discount are Q1.16 and values
// above 1.0 are clamped on write. Entries are appended in order and never
// removed; an update that finds the table full returns status 1 and stores
// nothing. There is no clearing pass after reset.
module q_table_update_engine
    import qtue_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [FRAC_W-1:0] i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // state_index[3:0], action_key[35:4], next_state[39:36], reward[55:40]
    input  logic [55:0]       s_axis_tdata,
    // operation[0]
    input  logic [0:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // q_result[31:0], best_action[63:32], inserted[64], zero fill [71:65]
    output logic [71:0]       m_axis_tdata,
    // status[1:0]
    output logic [1:0]        m_axis_tuser
);

    t_cmd                  w_cmd;
    t_stat                 w_stat;
    logic signed [Q_W-1:0] w_q_result;
    logic [KEY_W-1:0]      w_best_action;
    logic                  w_inserted;

    qtue_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    qtue_dp #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_op          (s_axis_tuser[0]),
        .i_state_index (s_axis_tdata[3:0]),
        .i_action_key  (s_axis_tdata[35:4]),
        .i_next_state  (s_axis_tdata[39:36]),
        .i_reward      (s_axis_tdata[55:40]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (m_axis_tuser),
        .o_q_result    (w_q_result),
        .o_best_action (w_best_action),
        .o_inserted    (w_inserted),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat)
    );

    assign m_axis_tdata = {7'd0, w_inserted, w_best_action, w_q_result};

`ifndef ASSERT_OFF
    a_inserted_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[64]) |-> (m_axis_tuser == ST_OK))
        else $error("inserted flag set on a result whose status is not ok");

    a_no_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_NO_ENTRY)) |-> (m_axis_tdata[64:0] == '0))
        else $error("no-entry result carries nonzero data");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a transaction is in progress");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> w_stat.out_free)
        else $error("result committed while the output register is occupied");
`endif

endmodule

FILE: verif/q_table_update_engine_tb.sv
// ----------------------------------------------------------------------------
// q_table_update_engine_tb
// Self-checking testbench of the Q table update engine.
// ----------------------------------------------------------------------------
// Items are sent on the input stream and mirrored into a model of the entry
// table, which predicts every result. Results are compared field by field in
// order of arrival. The run covers empty-table queries, inserts, ties in the
// best action search, saturation at both ends, clamped rate registers, a full
// table, a long output stall and random traffic under random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module q_table_update_engine_tb
    import qtue_pkg::*;
();

    localparam int TABLE_DEPTH = 256;

    typedef struct packed {
        logic               operation;
        logic [3:0]         state_index;
        logic [31:0]        action_key;
        logic [3:0]         next_state;
        logic signed [15:0] reward;
    } t_engine_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] q_result;
        logic [31:0]        best_action;
        logic               inserted;
    } t_engine_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_index = 1'b0;
    logic [FRAC_W-1:0] i_cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // state_index[3:0], action_key[35:4], next_state[39:36], reward[55:40]
    logic [55:0]       s_axis_tdata = '0;
    // operation[0]
    logic [0:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // q_result[31:0], best_action[63:32], inserted[64], zero fill [71:65]
    logic [71:0]       m_axis_tdata;
    // status[1:0]
    logic [1:0]        m_axis_tuser;

    t_engine_item   pending_items[$];
    t_engine_result expected_results[$];
    t_engine_item   offered_item;
    t_engine_result oldest_result;

    logic              tbl_valid [TABLE_DEPTH];
    logic [3:0]        tbl_state [TABLE_DEPTH];
    logic [31:0]       tbl_action[TABLE_DEPTH];
    int                tbl_qvalue[TABLE_DEPTH];
    int                tbl_count = 0;
    logic [FRAC_W-1:0] alpha_reg = ALPHA_RESET;
    logic [FRAC_W-1:0] gamma_reg = GAMMA_RESET;

    logic [31:0] key_pool[8];
    logic [63:0] noise_word;
    int          mismatch_count = 0;
    int          hold_left = 0;
    bit          no_idle = 1'b0;

    q_table_update_engine #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int sat_q16(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    function automatic t_engine_result predict_engine(input t_engine_item it);
        t_engine_result r;
        longint alpha, gamma, sample, blend;
        int     best_q, max_q, old_q, slot, i;
        bit     found, have_max, have_pair, stored;
        r.status = ST_OK;
        r.q_result = '0;
        r.best_action = '0;
        r.inserted = 1'b0;
        found = 1'b0;
        have_max = 1'b0;
        have_pair = 1'b0;
        stored = 1'b0;
        best_q = 0;
        max_q = 0;
        old_q = 0;
        slot = 0;
        if (it.operation == OP_QUERY) begin
            for (i = 0; i < tbl_count; i++) begin
                if (tbl_valid[i] && tbl_state[i] == it.state_index &&
                    (!found || tbl_qvalue[i] > best_q)) begin
                    found = 1'b1;
                    best_q = tbl_qvalue[i];
                    r.best_action = tbl_action[i];
                end
            end
            r.q_result = best_q;
            if (!found) begin
                r.status = ST_NO_ENTRY;
            end
            return r;
        end
        alpha = (alpha_reg > Q_ONE) ? longint'(Q_ONE) : longint'(alpha_reg);
        gamma = (gamma_reg > Q_ONE) ? longint'(Q_ONE) : longint'(gamma_reg);
        for (i = 0; i < tbl_count; i++) begin
            if (tbl_valid[i] && tbl_state[i] == it.next_state &&
                (!have_max || tbl_qvalue[i] > max_q)) begin
                have_max = 1'b1;
                max_q = tbl_qvalue[i];
            end
        end
        sample = longint'(it.reward) * 65536;
        if (have_max) begin
            sample = sample + ((gamma * longint'(max_q) + 32768) >>> 16);
        end
        sample = longint'(sat_q16(sample));
        for (i = 0; i < tbl_count && !have_pair; i++) begin
            if (tbl_valid[i] && tbl_state[i] == it.state_index &&
                tbl_action[i] == it.action_key) begin
                have_pair = 1'b1;
                slot = i;
                old_q = tbl_qvalue[i];
            end
        end
        stored = have_pair;
        if (!have_pair) begin
            old_q = 0;
            if (tbl_count < TABLE_DEPTH) begin
                slot = tbl_count;
                tbl_valid[slot] = 1'b1;
                tbl_state[slot] = it.state_index;
                tbl_action[slot] = it.action_key;
                tbl_count++;
                r.inserted = 1'b1;
                stored = 1'b1;
            end else begin
                r.status = ST_FULL;
            end
        end
        blend = (65536 - alpha) * longint'(old_q) + alpha * sample;
        r.q_result = sat_q16((blend + 32768) >>> 16);
        if (stored) begin
            tbl_qvalue[slot] = r.q_result;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.insert(expected_results.size(),
                                        predict_engine(offered_item));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() > 0 &&
                    (no_idle || $urandom_range(0, 99) >= 30)) begin
                    offered_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {offered_item.reward, offered_item.next_state,
                                     offered_item.action_key, offered_item.state_index};
                    s_axis_tuser <= offered_item.operation;
                end else begin
                    noise_word = {$urandom(), $urandom()};
                    s_axis_tvalid <= 1'b0;
                    s_axis_tdata <= noise_word[55:0];
                    s_axis_tuser <= noise_word[63];
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 30);
        end
    end

    task automatic note_mismatch(input string field, input logic [63:0] exp_val,
                                 input logic [63:0] act_val);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("Mismatch in %s: expected %h, actual %h", field, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                note_mismatch("unexpected transaction", '0, m_axis_tdata[63:0]);
            end else begin
                oldest_result = expected_results.pop_front();
                if (m_axis_tuser !== oldest_result.status) begin
                    note_mismatch("status", 64'(oldest_result.status), 64'(m_axis_tuser));
                end
                if (m_axis_tdata[31:0] !== oldest_result.q_result) begin
                    note_mismatch("q_result", 64'(oldest_result.q_result),
                                  64'($signed(m_axis_tdata[31:0])));
                end
                if (m_axis_tdata[63:32] !== oldest_result.best_action) begin
                    note_mismatch("best_action", 64'(oldest_result.best_action),
                                  64'(m_axis_tdata[63:32]));
                end
                if (m_axis_tdata[64] !== oldest_result.inserted) begin
                    note_mismatch("inserted", 64'(oldest_result.inserted),
                                  64'(m_axis_tdata[64]));
                end
            end
        end
    end

    task automatic send_item(input t_engine_item it);
        pending_items.insert(pending_items.size(), it);
        while (pending_items.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_fields(input logic op, input logic [3:0] st, input logic [31:0] act,
                               input logic [3:0] nst, input logic signed [15:0] rew);
        t_engine_item it;
        it.operation = op;
        it.state_index = st;
        it.action_key = act;
        it.next_state = nst;
        it.reward = rew;
        send_item(it);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic cfg_write(input logic idx, input logic [FRAC_W-1:0] val);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LEARN_RATE) begin
            alpha_reg = val;
        end else begin
            gamma_reg = val;
        end
    endtask

    function automatic logic [FRAC_W-1:0] pick_fraction();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return Q_ONE;
            2: return FRAC_W'($urandom_range(65537, 131071));
            default: return FRAC_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic random_config();
        cfg_write(CFG_LEARN_RATE, pick_fraction());
        cfg_write(CFG_DISCOUNT, pick_fraction());
    endtask

    function automatic t_engine_item random_item(input int query_pct, input int pool_pct);
        t_engine_item it;
        it.operation = ($urandom_range(0, 99) < query_pct) ? OP_QUERY : OP_UPDATE;
        it.state_index = 4'($urandom_range(0, 15));
        it.next_state = 4'($urandom_range(0, 15));
        it.action_key = ($urandom_range(0, 99) < pool_pct) ? key_pool[$urandom_range(0, 7)]
                                                          : $urandom();
        it.reward = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                : 16'(int'($urandom_range(0, 256)) - 128);
        return it;
    endfunction

    task automatic test_empty_queries();
        send_fields(OP_QUERY, 4'd0, 32'h0, 4'd0, 16'sd0);
        send_fields(OP_QUERY, 4'd15, 32'hffffffff, 4'd15, -16'sd1);
    endtask

    task automatic test_directed_updates();
        send_fields(OP_UPDATE, 4'd0, 32'h0, 4'd0, 16'sd32767);
        send_fields(OP_UPDATE, 4'd0, 32'h0, 4'd0, 16'sd32767);
        send_fields(OP_UPDATE, 4'd15, 32'hffffffff, 4'd15, -16'sd32768);
        send_fields(OP_UPDATE, 4'd15, 32'hffffffff, 4'd0, -16'sd32768);
        send_fields(OP_QUERY, 4'd0, 32'h0, 4'd0, 16'sd0);
        send_fields(OP_QUERY, 4'd15, 32'h0, 4'd0, 16'sd0);
    endtask

    task automatic test_best_action_ties();
        send_fields(OP_UPDATE, 4'd3, key_pool[2], 4'd9, 16'sd5);
        send_fields(OP_UPDATE, 4'd3, key_pool[3], 4'd9, 16'sd5);
        send_fields(OP_QUERY, 4'd3, 32'h0, 4'd0, 16'sd0);
        send_fields(OP_UPDATE, 4'd3, key_pool[4], 4'd9, 16'sd100);
        send_fields(OP_QUERY, 4'd3, 32'h0, 4'd0, 16'sd0);
    endtask

    task automatic test_rate_extremes();
        cfg_write(CFG_LEARN_RATE, Q_ONE);
        cfg_write(CFG_DISCOUNT, Q_ONE);
        send_fields(OP_UPDATE, 4'd1, 32'h1, 4'd1, 16'sd32767);
        send_fields(OP_UPDATE, 4'd1, 32'h1, 4'd1, 16'sd32767);
        send_fields(OP_UPDATE, 4'd2, 32'h2, 4'd2, -16'sd32768);
        send_fields(OP_UPDATE, 4'd2, 32'h2, 4'd2, -16'sd32768);
        send_fields(OP_QUERY, 4'd1, 32'h0, 4'd0, 16'sd0);
        send_fields(OP_QUERY, 4'd2, 32'h0, 4'd0, 16'sd0);
        cfg_write(CFG_LEARN_RATE, '0);
        cfg_write(CFG_DISCOUNT, 17'h1ffff);
        send_fields(OP_UPDATE, 4'd1, 32'h1, 4'd2, -16'sd1);
        cfg_write(CFG_LEARN_RATE, 17'h1ffff);
        cfg_write(CFG_DISCOUNT, '0);
        send_fields(OP_UPDATE, 4'd2, 32'h2, 4'd1, 16'sd7);
        send_fields(OP_QUERY, 4'd2, 32'h0, 4'd0, 16'sd0);
    endtask

    task automatic test_random_traffic(input int count, input int query_pct,
                                       input int pool_pct, input int burst_start);
        int n;
        for (n = 0; n < count; n++) begin
            if (n % 75 == 0) begin
                random_config();
            end
            no_idle = (n >= burst_start && n < burst_start + 100);
            send_item(random_item(query_pct, pool_pct));
        end
        no_idle = 1'b0;
    endtask

    task automatic test_output_stall();
        int n;
        hold_left = 3000;
        for (n = 0; n < 6; n++) begin
            send_item(random_item(20, 90));
        end
        wait_drained();
    endtask

    task automatic test_table_fill();
        int n;
        while (tbl_count < TABLE_DEPTH) begin
            send_item(random_item(0, 0));
        end
        for (n = 0; n < 12; n++) begin
            send_item(random_item(0, 0));
        end
        send_fields(OP_UPDATE, 4'd7, 32'h0bad0bad, 4'd0, 16'sd32767);
    endtask

    initial begin
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hffffffff;
        for (int k = 2; k < 8; k++) begin
            key_pool[k] = $urandom();
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_queries();
        test_directed_updates();
        test_best_action_ties();
        test_rate_extremes();
        test_random_traffic(360, 20, 90, 120);
        test_output_stall();
        test_table_fill();
        test_random_traffic(600, 25, 70, 300);
        wait_drained();
        repeat (300) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #12000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
